// ===== sv/gdc_pkg.sv =====
// Shared types and constants of the gesture direction classifier.
`timescale 1ns / 1ps

package gdc_pkg;

   localparam int SAMPLE_BITS = 8;
   localparam int SET_BITS    = 4 * SAMPLE_BITS;
   localparam int DEN_BITS    = SAMPLE_BITS + 1;
   localparam int QUOT_BITS   = 7;
   localparam int NUM_BITS    = DEN_BITS + QUOT_BITS - 1;
   localparam int DELTA_BITS  = 9;
   localparam int THR_BITS    = 8;
   localparam int DSENS_BITS  = 9;
   localparam int SSENS_BITS  = 8;
   localparam int COUNT_BITS  = 8;
   localparam int RATIO_SCALE = 100;
   localparam int NEAR_LIMIT  = 10;
   localparam int FAR_LIMIT   = 2;

   localparam logic [THR_BITS-1:0]   THR_RESET   = 8'd10;
   localparam logic [DSENS_BITS-1:0] DSENS_RESET = 9'd50;
   localparam logic [SSENS_BITS-1:0] SSENS_RESET = 8'd20;

   localparam logic [1:0] REG_VALID_THRESHOLD       = 2'd0;
   localparam logic [1:0] REG_DIRECTION_SENSITIVITY = 2'd1;
   localparam logic [1:0] REG_STILLNESS_SENSITIVITY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_ACC,
      ST_VOTE,
      ST_PROX
   } gdc_state_type;

   typedef enum logic [1:0] {
      VOTE_NONE,
      VOTE_POS,
      VOTE_NEG
   } vote_type;

   typedef enum logic [1:0] {
      PROX_NONE,
      PROX_NEAR,
      PROX_FAR
   } prox_type;

   typedef enum logic [2:0] {
      MOTION_NONE,
      MOTION_LEFT,
      MOTION_RIGHT,
      MOTION_UP,
      MOTION_DOWN,
      MOTION_NEAR,
      MOTION_FAR
   } motion_type;

   typedef struct packed {
      logic                         done;
      logic signed [QUOT_BITS:0]    quot;
   } div_result_type;

endpackage

// ===== sv/gdc_ratio_div.sv =====
// Bit-serial divider for the truncated ratio (a-b)*100/(a+b) of two samples.
`timescale 1ns / 1ps

module gdc_ratio_div import gdc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SAMPLE_BITS-1:0] a_value,
   input  logic [SAMPLE_BITS-1:0] b_value,
   output div_result_type         result
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]    rem_ff, rem_in;
   logic [NUM_BITS-1:0]    dv_ff, dv_in;
   logic [QUOT_BITS-1:0]   q_ff, q_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;

   logic [SAMPLE_BITS-1:0] diff;
   logic [DEN_BITS-1:0]    den;
   logic [QUOT_BITS:0]     q_mag;

   assign diff = (a_value >= b_value) ? (a_value - b_value) : (b_value - a_value);
   assign den  = {1'b0, a_value} + {1'b0, b_value};

   // The quotient magnitude never reaches 128, so the divisor starts six places up
   // and one quotient bit is settled per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start) begin
         rem_in  = NUM_BITS'(diff) * NUM_BITS'(RATIO_SCALE);
         dv_in   = {den, {(QUOT_BITS-1){1'b0}}};
         q_in    = '0;
         neg_in  = (a_value < b_value);
         zero_in = (den == '0);
         cnt_in  = 3'(QUOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= dv_ff) begin
            rem_in = rem_ff - dv_ff;
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUOT_BITS-2:0], 1'b0};
         end
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign q_mag       = {1'b0, q_ff};
   assign result.done = done_ff;
   assign result.quot = zero_ff ? '0 : (neg_ff ? signed'(-q_mag) : signed'(q_mag));

endmodule

// ===== sv/gesture_direction_classifier.sv =====
// Top level of the gesture direction classifier: sample intake, batch close and decode.
`timescale 1ns / 1ps

// A sample that closes a batch holding at least one valid set keeps the block
// busy while the four ratios go one after another through a single bit-serial
// divider that settles one quotient bit per cycle, followed by the accumulator
// update, the votes and the near/far decision, each in a state of its own.
// Every transaction, sample or finish, is accepted only when the result
// register is free or being emptied in the same cycle, so a waiting result holds
// off the input. Configuration registers sit at byte addresses 0, 4 and 8; the
// user is to write them only while the block is idle, and the block itself does
// not enforce this.
module gesture_direction_classifier import gdc_pkg::*; #(
   parameter int ACCUM_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [SAMPLE_BITS-1:0] req_up_sample,
   input  logic [SAMPLE_BITS-1:0] req_down_sample,
   input  logic [SAMPLE_BITS-1:0] req_left_sample,
   input  logic [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                   req_batch_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_motion,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   gdc_state_type state_ff, state_in;

   logic [THR_BITS-1:0]   thr_ff;
   logic [DSENS_BITS-1:0] dsens_ff;
   logic [SSENS_BITS-1:0] ssens_ff;

   logic [SET_BITS-1:0]   first_ff, first_in;
   logic [SET_BITS-1:0]   last_ff, last_in;
   logic                  found_ff, found_in;
   logic signed [ACCUM_BITS-1:0] vacc_ff, vacc_in;
   logic signed [ACCUM_BITS-1:0] hacc_ff, hacc_in;
   vote_type              vvote_ff, vvote_in;
   vote_type              hvote_ff, hvote_in;
   logic [COUNT_BITS-1:0] near_ff, near_in;
   logic [COUNT_BITS-1:0] far_ff, far_in;
   prox_type              prox_ff, prox_in;
   motion_type            motion_ff, motion_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   motion_type            rsp_motion_ff, rsp_motion_in;
   logic [1:0]            idx_ff, idx_in;
   logic signed [DELTA_BITS-1:0] ud_ff, ud_in;
   logic signed [DELTA_BITS-1:0] lrd_ff, lrd_in;

   logic                  req_accept;
   logic                  hit;
   logic [SET_BITS-1:0]   packed_set;
   logic                  div_start;
   logic [SAMPLE_BITS-1:0] div_a, div_b;
   div_result_type        div_res;
   logic                  cfg_write;

   function automatic logic signed [ACCUM_BITS-1:0] sat_add(
      input logic signed [ACCUM_BITS-1:0] acc,
      input logic signed [DELTA_BITS-1:0] d
   );
      logic signed [ACCUM_BITS:0] sum;
      sum = {acc[ACCUM_BITS-1], acc} + {{(ACCUM_BITS + 1 - DELTA_BITS){d[DELTA_BITS-1]}}, d};
      if (sum[ACCUM_BITS] != sum[ACCUM_BITS-1]) begin
         return sum[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                                : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      end
      return sum[ACCUM_BITS-1:0];
   endfunction

   function automatic vote_type vote_of(
      input logic signed [ACCUM_BITS-1:0] acc,
      input logic [DSENS_BITS-1:0] sens
   );
      logic signed [ACCUM_BITS:0] a_ext;
      logic signed [ACCUM_BITS:0] s_ext;
      a_ext = {acc[ACCUM_BITS-1], acc};
      s_ext = signed'({{(ACCUM_BITS + 1 - DSENS_BITS){1'b0}}, sens});
      if (a_ext >= s_ext) return VOTE_POS;
      if (a_ext <= -s_ext) return VOTE_NEG;
      return VOTE_NONE;
   endfunction

   function automatic logic [ACCUM_BITS-1:0] acc_mag(input logic signed [ACCUM_BITS-1:0] v);
      return v[ACCUM_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DELTA_BITS-1:0] delta_mag(input logic signed [DELTA_BITS-1:0] v);
      return v[DELTA_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
   endfunction

   // Proximity wins over direction; diagonal votes go to the axis with the
   // larger accumulated magnitude. With no vote the previous motion stands.
   function automatic motion_type decode(
      input prox_type   p,
      input vote_type   v,
      input vote_type   h,
      input logic       vert_wins,
      input motion_type prev
   );
      motion_type m;
      m = prev;
      if (p == PROX_NEAR) m = MOTION_NEAR;
      else if (p == PROX_FAR) m = MOTION_FAR;
      else if (v == VOTE_NEG && h == VOTE_NONE) m = MOTION_UP;
      else if (v == VOTE_POS && h == VOTE_NONE) m = MOTION_DOWN;
      else if (v == VOTE_NONE && h == VOTE_POS) m = MOTION_RIGHT;
      else if (v == VOTE_NONE && h == VOTE_NEG) m = MOTION_LEFT;
      else if (v == VOTE_NEG && h == VOTE_POS) m = vert_wins ? MOTION_UP : MOTION_RIGHT;
      else if (v == VOTE_POS && h == VOTE_NEG) m = vert_wins ? MOTION_DOWN : MOTION_LEFT;
      else if (v == VOTE_NEG && h == VOTE_NEG) m = vert_wins ? MOTION_UP : MOTION_LEFT;
      else if (v == VOTE_POS && h == VOTE_POS) m = vert_wins ? MOTION_DOWN : MOTION_RIGHT;
      return m;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign hit = (req_up_sample > thr_ff) && (req_down_sample > thr_ff) &&
                (req_left_sample > thr_ff) && (req_right_sample > thr_ff);
   assign packed_set = {req_up_sample, req_down_sample, req_left_sample, req_right_sample};

   // Ratio order: last up/down, first up/down, last left/right, first left/right.
   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            div_a = last_ff[31:24];
            div_b = last_ff[23:16];
         end
         2'd1: begin
            div_a = first_ff[31:24];
            div_b = first_ff[23:16];
         end
         2'd2: begin
            div_a = last_ff[15:8];
            div_b = last_ff[7:0];
         end
         default: begin
            div_a = first_ff[15:8];
            div_b = first_ff[7:0];
         end
      endcase
   end

   gdc_ratio_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .a_value (div_a),
      .b_value (div_b),
      .result  (div_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !req_op && req_batch_end && (found_ff || hit)) state_in = ST_START;
         end
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_res.done) state_in = (idx_ff == 2'd3) ? ST_ACC : ST_START;
         end
         ST_ACC:  state_in = ST_VOTE;
         ST_VOTE: state_in = ST_PROX;
         ST_PROX: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake and divider control.
   always_comb begin
      req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      div_start = (state_ff == ST_START);
   end

   // Datapath.
   always_comb begin
      logic still;
      logic both_zero;
      logic both_nonzero;
      logic [COUNT_BITS-1:0] near_new;
      logic [COUNT_BITS-1:0] far_new;
      logic signed [DELTA_BITS-1:0] q_ext;

      first_in      = first_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      vacc_in       = vacc_ff;
      hacc_in       = hacc_ff;
      vvote_in      = vvote_ff;
      hvote_in      = hvote_ff;
      near_in       = near_ff;
      far_in        = far_ff;
      prox_in       = prox_ff;
      motion_in     = motion_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_motion_in = rsp_motion_ff;
      idx_in        = idx_ff;
      ud_in         = ud_ff;
      lrd_in        = lrd_ff;

      still = (delta_mag(ud_ff) < DELTA_BITS'(ssens_ff)) &&
              (delta_mag(lrd_ff) < DELTA_BITS'(ssens_ff));
      both_zero    = (ud_ff == '0) && (lrd_ff == '0);
      both_nonzero = (ud_ff != '0) && (lrd_ff != '0);
      near_new     = near_ff;
      far_new      = far_ff;
      q_ext        = {div_res.quot[QUOT_BITS], div_res.quot};

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_op) begin
                  rsp_valid_in  = 1'b1;
                  rsp_motion_in = decode(prox_ff, vvote_ff, hvote_ff,
                                         acc_mag(vacc_ff) > acc_mag(hacc_ff), motion_ff);
                  first_in  = '0;
                  last_in   = '0;
                  found_in  = 1'b0;
                  vacc_in   = '0;
                  hacc_in   = '0;
                  vvote_in  = VOTE_NONE;
                  hvote_in  = VOTE_NONE;
                  near_in   = '0;
                  far_in    = '0;
                  prox_in   = PROX_NONE;
                  motion_in = MOTION_NONE;
               end else begin
                  if (hit) begin
                     if (!found_ff) first_in = packed_set;
                     found_in = 1'b1;
                     last_in  = packed_set;
                  end
                  ud_in  = '0;
                  lrd_in = '0;
                  idx_in = 2'd0;
               end
            end
         end
         ST_WAIT: begin
            if (div_res.done) begin
               unique case (idx_ff)
                  2'd0:    ud_in  = ud_ff + q_ext;
                  2'd1:    ud_in  = ud_ff - q_ext;
                  2'd2:    lrd_in = lrd_ff + q_ext;
                  default: lrd_in = lrd_ff - q_ext;
               endcase
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_ACC: begin
            vacc_in = sat_add(vacc_ff, ud_ff);
            hacc_in = sat_add(hacc_ff, lrd_ff);
         end
         ST_VOTE: begin
            vvote_in = vote_of(vacc_ff, dsens_ff);
            hvote_in = vote_of(hacc_ff, dsens_ff);
         end
         ST_PROX: begin
            if (vvote_ff == VOTE_NONE && hvote_ff == VOTE_NONE) begin
               if (still) begin
                  if (both_zero) near_new = bump(near_ff);
                  else far_new = bump(far_ff);
                  near_in = near_new;
                  far_in  = far_new;
                  if (near_new >= COUNT_BITS'(NEAR_LIMIT) && far_new >= COUNT_BITS'(FAR_LIMIT)) begin
                     if (both_zero) begin
                        prox_in = PROX_NEAR;
                     end else if (both_nonzero) begin
                        prox_in = PROX_FAR;
                     end
                     motion_in = decode(prox_in, VOTE_NONE, VOTE_NONE, 1'b0, motion_ff);
                  end
               end
            end else if (still) begin
               if (both_zero) near_new = bump(near_ff);
               near_in = near_new;
               if (near_new >= COUNT_BITS'(NEAR_LIMIT)) begin
                  vvote_in = VOTE_NONE;
                  hvote_in = VOTE_NONE;
                  vacc_in  = '0;
                  hacc_in  = '0;
               end
            end
            first_in = '0;
            last_in  = '0;
            found_in = 1'b0;
         end
         default: begin
         end
      endcase

      // A batch end without any valid set only closes the batch.
      if (state_ff == ST_IDLE && req_accept && !req_op && req_batch_end && !(found_ff || hit)) begin
         found_in = 1'b0;
         first_in = '0;
         last_in  = '0;
      end
   end

   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         dsens_ff     <= DSENS_RESET;
         ssens_ff     <= SSENS_RESET;
         first_ff     <= '0;
         last_ff      <= '0;
         found_ff     <= 1'b0;
         vacc_ff      <= '0;
         hacc_ff      <= '0;
         vvote_ff     <= VOTE_NONE;
         hvote_ff     <= VOTE_NONE;
         near_ff      <= '0;
         far_ff       <= '0;
         prox_ff      <= PROX_NONE;
         motion_ff    <= MOTION_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         found_ff     <= found_in;
         vacc_ff      <= vacc_in;
         hacc_ff      <= hacc_in;
         vvote_ff     <= vvote_in;
         hvote_ff     <= hvote_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         prox_ff      <= prox_in;
         motion_ff    <= motion_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            unique case (paddr[3:2])
               REG_VALID_THRESHOLD:       thr_ff   <= pwdata[THR_BITS-1:0];
               REG_DIRECTION_SENSITIVITY: dsens_ff <= pwdata[DSENS_BITS-1:0];
               REG_STILLNESS_SENSITIVITY: ssens_ff <= pwdata[SSENS_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_motion_ff <= rsp_motion_in;
      idx_ff        <= idx_in;
      ud_ff         <= ud_in;
      lrd_ff        <= lrd_in;
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_VALID_THRESHOLD:       prdata = {{(32 - THR_BITS){1'b0}}, thr_ff};
         REG_DIRECTION_SENSITIVITY: prdata = {{(32 - DSENS_BITS){1'b0}}, dsens_ff};
         REG_STILLNESS_SENSITIVITY: prdata = {{(32 - SSENS_BITS){1'b0}}, ssens_ff};
         default:                   prdata = '0;
      endcase
   end

   assign pready     = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_motion = rsp_motion_ff;

endmodule

// ===== tb/gesture_direction_classifier_tb.sv =====
// Self-checking testbench for the gesture direction classifier.
`timescale 1ns / 1ps

module gesture_direction_classifier_tb;
   import gdc_pkg::*;

   // Keeps its own copy of the gesture state and the registers, works out the motion
   // that each finish transaction should report and checks the results in order.
   class motion_scoreboard #(int ACC_W = 16);
      localparam longint ACC_MAX = (longint'(1) << (ACC_W - 1)) - 1;
      localparam longint ACC_MIN = -ACC_MAX - 1;

      logic [THR_BITS-1:0]   thr;
      logic [DSENS_BITS-1:0] dir_sens;
      logic [SSENS_BITS-1:0] still_sens;

      logic [SET_BITS-1:0]   first_pack;
      logic [SET_BITS-1:0]   last_pack;
      bit                    have_first;
      longint                vacc;
      longint                hacc;
      vote_type              vvote;
      vote_type              hvote;
      logic [COUNT_BITS-1:0] near_cnt;
      logic [COUNT_BITS-1:0] far_cnt;
      prox_type              prox;
      motion_type            motion_latch;

      motion_type            expected_motion[$];
      int                    failures;
      int                    checked;

      function new();
         thr = THR_RESET;
         dir_sens = DSENS_RESET;
         still_sens = SSENS_RESET;
         failures = 0;
         checked = 0;
         clear_gesture();
      endfunction

      function void clear_gesture();
         first_pack = '0;
         last_pack = '0;
         have_first = 1'b0;
         vacc = 0;
         hacc = 0;
         vvote = VOTE_NONE;
         hvote = VOTE_NONE;
         near_cnt = '0;
         far_cnt = '0;
         prox = PROX_NONE;
         motion_latch = MOTION_NONE;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_VALID_THRESHOLD:       thr = value[THR_BITS-1:0];
            REG_DIRECTION_SENSITIVITY: dir_sens = value[DSENS_BITS-1:0];
            REG_STILLNESS_SENSITIVITY: still_sens = value[SSENS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_motion.size();
      endfunction

      function int pair_ratio(int a, int b);
         if (a + b == 0) begin
            return 0;
         end
         return (a - b) * RATIO_SCALE / (a + b);
      endfunction

      function longint magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function longint saturate(longint acc, longint step);
         longint s;
         s = acc + step;
         if (s > ACC_MAX) begin
            return ACC_MAX;
         end
         if (s < ACC_MIN) begin
            return ACC_MIN;
         end
         return s;
      endfunction

      function vote_type vote_for(longint acc);
         if (acc >= longint'(dir_sens)) begin
            return VOTE_POS;
         end
         if (acc <= -longint'(dir_sens)) begin
            return VOTE_NEG;
         end
         return VOTE_NONE;
      endfunction

      function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] c);
         return (c == '1) ? c : c + 1'b1;
      endfunction

      // Without a latched proximity and without any vote the motion is left as it was.
      function void resolve_motion();
         bit vert_wins;
         vert_wins = magnitude(vacc) > magnitude(hacc);
         if (prox == PROX_NEAR) begin
            motion_latch = MOTION_NEAR;
         end else if (prox == PROX_FAR) begin
            motion_latch = MOTION_FAR;
         end else if (vvote == VOTE_NEG && hvote == VOTE_NONE) begin
            motion_latch = MOTION_UP;
         end else if (vvote == VOTE_POS && hvote == VOTE_NONE) begin
            motion_latch = MOTION_DOWN;
         end else if (vvote == VOTE_NONE && hvote == VOTE_POS) begin
            motion_latch = MOTION_RIGHT;
         end else if (vvote == VOTE_NONE && hvote == VOTE_NEG) begin
            motion_latch = MOTION_LEFT;
         end else if (vvote == VOTE_NEG && hvote == VOTE_POS) begin
            motion_latch = vert_wins ? MOTION_UP : MOTION_RIGHT;
         end else if (vvote == VOTE_POS && hvote == VOTE_NEG) begin
            motion_latch = vert_wins ? MOTION_DOWN : MOTION_LEFT;
         end else if (vvote == VOTE_NEG && hvote == VOTE_NEG) begin
            motion_latch = vert_wins ? MOTION_UP : MOTION_LEFT;
         end else if (vvote == VOTE_POS && hvote == VOTE_POS) begin
            motion_latch = vert_wins ? MOTION_DOWN : MOTION_RIGHT;
         end
      endfunction

      function void close_batch();
         int     fu, fd, fl, fr, lu, ld, ll, lr;
         longint ud, lrd;
         bit     still, both_zero;
         fu = int'(first_pack[31:24]);
         fd = int'(first_pack[23:16]);
         fl = int'(first_pack[15:8]);
         fr = int'(first_pack[7:0]);
         lu = int'(last_pack[31:24]);
         ld = int'(last_pack[23:16]);
         ll = int'(last_pack[15:8]);
         lr = int'(last_pack[7:0]);
         ud = longint'(pair_ratio(lu, ld) - pair_ratio(fu, fd));
         lrd = longint'(pair_ratio(ll, lr) - pair_ratio(fl, fr));
         still = magnitude(ud) < longint'(still_sens) && magnitude(lrd) < longint'(still_sens);
         both_zero = (ud == 0) && (lrd == 0);

         vacc = saturate(vacc, ud);
         hacc = saturate(hacc, lrd);
         vvote = vote_for(vacc);
         hvote = vote_for(hacc);

         if (vvote == VOTE_NONE && hvote == VOTE_NONE) begin
            if (still) begin
               if (both_zero) begin
                  near_cnt = bump(near_cnt);
               end else begin
                  far_cnt = bump(far_cnt);
               end
               if (near_cnt >= NEAR_LIMIT && far_cnt >= FAR_LIMIT) begin
                  // With exactly one delta at zero the proximity is left alone.
                  if (both_zero) begin
                     prox = PROX_NEAR;
                  end else if (ud != 0 && lrd != 0) begin
                     prox = PROX_FAR;
                  end
                  resolve_motion();
               end
            end
         end else if (still) begin
            if (both_zero) begin
               near_cnt = bump(near_cnt);
            end
            if (near_cnt >= NEAR_LIMIT) begin
               vvote = VOTE_NONE;
               hvote = VOTE_NONE;
               vacc = 0;
               hacc = 0;
            end
         end
      endfunction

      function void note_request(logic op, logic [7:0] u, d, l, r, logic be);
         if (op) begin
            resolve_motion();
            expected_motion.push_back(motion_latch);
            clear_gesture();
            return;
         end
         if (u > thr && d > thr && l > thr && r > thr) begin
            if (!have_first) begin
               first_pack = {u, d, l, r};
               have_first = 1'b1;
            end
            last_pack = {u, d, l, r};
         end
         if (be) begin
            if (have_first) begin
               close_batch();
            end
            have_first = 1'b0;
            first_pack = '0;
            last_pack = '0;
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         failures++;
      endtask

      task check_motion(logic [2:0] got);
         motion_type want;
         checked++;
         if (expected_motion.size() == 0) begin
            report_mismatch($sformatf("motion %0d arrived with none expected", got));
            return;
         end
         want = expected_motion.pop_front();
         if (got !== want) begin
            report_mismatch($sformatf("motion %0d, expected %0d (%s)", got, want, want.name()));
         end
      endtask
   endclass

   localparam int         ACCUM_BITS    = 16;
   localparam logic [1:0] REG_SPARE     = 2'd3;
   localparam int         SETTLE_CYCLES = 60;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_op;
   logic [SAMPLE_BITS-1:0] req_up_sample;
   logic [SAMPLE_BITS-1:0] req_down_sample;
   logic [SAMPLE_BITS-1:0] req_left_sample;
   logic [SAMPLE_BITS-1:0] req_right_sample;
   logic                   req_batch_end;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_motion;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [3:0]             paddr;
   logic [31:0]            pwdata;
   logic [31:0]            prdata;
   logic                   pready;

   motion_scoreboard #(ACCUM_BITS) sb;
   int idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int settings_used = 1;

   gesture_direction_classifier #(.ACCUM_BITS(ACCUM_BITS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_up_sample    (req_up_sample),
      .req_down_sample  (req_down_sample),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_motion       (rsp_motion),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   // Result side: a transaction seen at this edge is checked, then ready is redrawn.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_motion(rsp_motion);
      end
      rsp_ready <= ($urandom % 100) >= stall_pct;
   end

   task automatic set_idling(int mode);
      case (mode)
         1: begin
            idle_pct = 49;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 49;
         end
         3: begin
            idle_pct = 27;
            stall_pct = 27;
         end
         default: begin
            idle_pct = 0;
            stall_pct = 0;
         end
      endcase
   endtask

   task automatic send_item(logic op, logic [7:0] u, d, l, r, logic be);
      int gap;
      gap = 0;
      while (($urandom % 100) < idle_pct && gap < 20) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_up_sample <= u;
      req_down_sample <= d;
      req_left_sample <= l;
      req_right_sample <= r;
      req_batch_end <= be;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, u, d, l, r, be);
      items_sent++;
   endtask

   task automatic send_finish();
      send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // Waits on the clock before testing, so valid is never lowered and raised in one step.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int value);
      logic [31:0] keep;
      logic [31:0] data;
      case (idx)
         REG_VALID_THRESHOLD:       keep = (32'd1 << THR_BITS) - 1;
         REG_DIRECTION_SENSITIVITY: keep = (32'd1 << DSENS_BITS) - 1;
         REG_STILLNESS_SENSITIVITY: keep = (32'd1 << SSENS_BITS) - 1;
         default:                   keep = '0;
      endcase
      // Bits above the register width carry noise that the block must drop.
      data = ($urandom & ~keep) | (value & keep);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_register(idx, data);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      // The address is still held, so the read data shows the register just written.
      if (prdata !== (data & keep)) begin
         sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                      idx, prdata, data & keep));
      end
   endtask

   task automatic configure(int t, int ds, int ss);
      csr_write(REG_VALID_THRESHOLD, t);
      csr_write(REG_DIRECTION_SENSITIVITY, ds);
      csr_write(REG_STILLNESS_SENSITIVITY, ss);
      settings_used++;
   endtask

   function automatic int sample_floor();
      return (sb.thr == '1) ? 255 : int'(sb.thr) + 1;
   endfunction

   function automatic logic [7:0] shade(int level, int pct);
      int v;
      v = level * (100 - pct) / 100;
      if (v < sample_floor()) begin
         v = sample_floor();
      end
      if (v > 255) begin
         v = 255;
      end
      return v[7:0];
   endfunction

   // A positive bias makes up brighter than down, and left brighter than right.
   task automatic put_set(int level, int vb, int hb, logic be, bit spotty);
      logic [7:0] u, d, l, r;
      if (vb >= 0) begin
         u = 8'(level);
         d = shade(level, vb);
      end else begin
         u = shade(level, -vb);
         d = 8'(level);
      end
      if (hb >= 0) begin
         l = 8'(level);
         r = shade(level, hb);
      end else begin
         l = shade(level, -hb);
         r = 8'(level);
      end
      if (spotty && ($urandom % 10) == 0) begin
         case ($urandom % 4)
            0: u = 8'($urandom_range(0, sample_floor() - 1));
            1: d = 8'($urandom_range(0, sample_floor() - 1));
            2: l = 8'($urandom_range(0, sample_floor() - 1));
            default: r = 8'($urandom_range(0, sample_floor() - 1));
         endcase
      end
      send_item(1'b0, u, d, l, r, be);
   endtask

   // A hand sweeping across the sensor; an open end leaves the last batch unclosed.
   task automatic run_swipe(bit open_end);
      int axis, n, lvl, vs, ve, hs, he, k;
      logic be;
      axis = $urandom_range(0, 2);
      vs = int'($urandom_range(30, 90)) * ((($urandom % 2) == 0) ? 1 : -1);
      ve = -vs;
      hs = int'($urandom_range(30, 90)) * ((($urandom % 2) == 0) ? 1 : -1);
      he = -hs;
      if (axis == 1) begin
         vs = int'($urandom_range(0, 10)) - 5;
         ve = vs;
      end
      if (axis == 0) begin
         hs = int'($urandom_range(0, 10)) - 5;
         he = hs;
      end
      n = $urandom_range(2, 12);
      lvl = $urandom_range(255, sample_floor());
      for (k = 0; k < n; k++) begin
         be = (k == n - 1) ? !open_end : (($urandom % 4) == 0);
         put_set(lvl, vs + (ve - vs) * k / (n - 1), hs + (he - hs) * k / (n - 1), be, 1'b1);
      end
   endtask

   // Mostly unchanged single batches (near) with a few slightly drifting ones (far).
   task automatic run_hover();
      int nb, b, j, reps, vb, hb, lvl;
      nb = $urandom_range(10, 16);
      vb = int'($urandom_range(0, 60)) - 30;
      hb = int'($urandom_range(0, 60)) - 30;
      lvl = $urandom_range(255, sample_floor());
      for (b = 0; b < nb; b++) begin
         if (($urandom % 4) == 0) begin
            put_set(lvl, vb, hb, 1'b0, 1'b0);
            put_set(lvl, vb + int'($urandom_range(0, 12)) - 6,
                    hb + int'($urandom_range(0, 12)) - 6, 1'b1, 1'b0);
         end else begin
            reps = $urandom_range(1, 3);
            for (j = 0; j < reps; j++) begin
               put_set(lvl, vb, hb, j == reps - 1, 1'b0);
            end
         end
      end
   endtask

   task automatic run_noise();
      int n, k;
      n = $urandom_range(3, 12);
      for (k = 0; k < n; k++) begin
         send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   ($urandom % 3) == 0);
      end
   endtask

   task automatic run_empty_batches();
      int n, k;
      logic [7:0] u;
      n = $urandom_range(2, 8);
      for (k = 0; k < n; k++) begin
         u = 8'($urandom_range(0, sample_floor() - 1));
         send_item(1'b0, u, 8'($urandom), 8'($urandom), 8'($urandom),
                   (k == n - 1) || (($urandom % 2) == 0));
      end
   endtask

   // Batches in one direction that, at the reset threshold, saturate the accumulator.
   task automatic run_saturation(bit toward_down);
      int k;
      logic [7:0] lo, hi;
      lo = 8'(sample_floor());
      hi = 8'd255;
      for (k = 0; k < 190; k++) begin
         if (toward_down) begin
            send_item(1'b0, lo, hi, hi, hi, 1'b0);
            send_item(1'b0, hi, lo, hi, hi, 1'b1);
         end else begin
            send_item(1'b0, hi, lo, hi, hi, 1'b0);
            send_item(1'b0, lo, hi, hi, hi, 1'b1);
         end
      end
      send_finish();
   endtask

   task automatic run_gesture();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         run_swipe(1'b0);
      end else if (kind < 65) begin
         run_hover();
      end else if (kind < 78) begin
         run_noise();
      end else if (kind < 88) begin
         run_swipe(1'b1);
      end else if (kind < 97) begin
         run_empty_batches();
      end else if (kind < 99) begin
         run_hover();
         run_swipe(1'b0);
      end else begin
         run_saturation(1'($urandom));
      end
      if (($urandom % 8) == 0) begin
         hold_until_drained();
      end
      if (($urandom % 10) != 0) begin
         send_finish();
      end
   endtask

   initial begin
      int p, k, target;
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= 1'b0;
      req_up_sample <= '0;
      req_down_sample <= '0;
      req_left_sample <= '0;
      req_right_sample <= '0;
      req_batch_end <= 1'b0;
      rsp_ready <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions under the reset register values.
      set_idling(0);
      send_finish();
      send_item(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_item(1'b0, 8'd10, 8'd10, 8'd10, 8'd10, 1'b0);
      send_item(1'b0, 8'd255, 8'd11, 8'd128, 8'd128, 1'b0);
      send_item(1'b0, 8'd11, 8'd255, 8'd128, 8'd128, 1'b1);
      send_finish();
      send_item(1'b0, 8'd128, 8'd128, 8'd11, 8'd255, 1'b0);
      send_item(1'b0, 8'd128, 8'd128, 8'd255, 8'd11, 1'b1);
      send_finish();
      send_item(1'b0, 8'd11, 8'd255, 8'd128, 8'd128, 1'b0);
      send_item(1'b0, 8'd255, 8'd11, 8'd128, 8'd128, 1'b1);
      send_finish();
      send_item(1'b0, 8'd128, 8'd128, 8'd255, 8'd11, 1'b0);
      send_item(1'b0, 8'd128, 8'd128, 8'd11, 8'd255, 1'b1);
      send_finish();
      send_item(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_finish();
      // A finish arriving while a batch is open discards that batch.
      send_item(1'b0, 8'd200, 8'd20, 8'd100, 8'd100, 1'b0);
      send_item(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_item(1'b0, 8'd255, 8'd11, 8'd255, 8'd11, 1'b0);
      send_item(1'b0, 8'd11, 8'd255, 8'd11, 8'd200, 1'b1);
      send_finish();

      run_saturation(1'b0);
      target = items_sent + 150;
      while (items_sent < target) begin
         run_gesture();
      end

      for (p = 1; p <= 8; p++) begin
         settle();
         case (p)
            1: configure(0, 400, 200);
            2: configure(255, 0, 0);
            3: begin
               configure(10, 50, 20);
               csr_write(REG_SPARE, $urandom);
            end
            default: configure($urandom_range(0, 40), $urandom_range(0, 200),
                               $urandom_range(0, 200));
         endcase
         set_idling(p % 4);
         target = items_sent + 220;
         while (items_sent < target) begin
            run_gesture();
         end
      end

      req_valid <= 1'b0;
      for (k = 0; k < 50000 && sb.pending() != 0; k++) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch($sformatf("%0d motion results never arrived", sb.pending()));
      end

      $display("Drove %0d request transactions under %0d register settings and four idling mixes.",
               items_sent, settings_used);
      $display("Checked %0d motion results against the predicted decode.", sb.checked);
      if (sb.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timed out waiting for the block");
      $display("Mismatches found");
      $finish;
   end

endmodule
